@@ rtl/frame_deadline_pacer_top_assert.svh @@
`ifndef FRAME_DEADLINE_PACER_TOP_ASSERT_SVH
`define FRAME_DEADLINE_PACER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define FDP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define FDP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/fdp_pkg.sv @@
`default_nettype none

package fdp_pkg;

    // Field widths
    localparam int PERIOD_W = 24;
    localparam int SLEEP_W  = 31;
    localparam int DROP_W   = 32;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 24'd16667;
    localparam logic [SLEEP_W-1:0]  SLEEP_MAX    = 31'h7FFF_FFFF;
    localparam logic [DROP_W-1:0]   DROP_MAX     = 32'hFFFF_FFFF;

    // Shared adder operation
    typedef logic t_alu_op;
    localparam t_alu_op ALU_ADD = 1'b0;
    localparam t_alu_op ALU_SUB = 1'b1;

endpackage

`default_nettype wire

@@ rtl/frame_deadline_pacer_top.sv @@
// Sequence: from item accept through S_NEXT and S_CMP to S_OUT when ahead of the deadline;
//   when behind it adds S_ND and S_ELAP, and with a nonzero period also S_DIV and S_DEC;
//   the restoring divide runs one quotient bit per cycle through the single shared adder.
// One item at a time: input ready only while the sequencer idles, and the sequencer
//   waits in its output step while a result is held.
// Reset (synchronous, active low): deadline cleared (not seeded), period 16667.
`default_nettype none

module frame_deadline_pacer_top #(
    parameter int TIME_BITS = 64
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // Config write: frame_period
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [23:0]  i_cfg_data,   // [23:0] frame_period
    // Input stream
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [63:0]  s_axis_tdata,  // [63:0] now_us
    // Result stream
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [127:0]      m_axis_tdata,  // [30:0] sleep_us, [94:31] next_deadline,
                                             // [126:95] dropped_frames, [127] zero
    output logic [0:0]        m_axis_tuser   // [0] behind
);

    localparam int TB    = TIME_BITS;
    localparam int PW    = fdp_pkg::PERIOD_W;
    localparam int CNT_W = $clog2(TIME_BITS);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_NEXT = 3'd1;
    localparam logic [2:0] S_CMP  = 3'd2;
    localparam logic [2:0] S_ND   = 3'd3;
    localparam logic [2:0] S_ELAP = 3'd4;
    localparam logic [2:0] S_DIV  = 3'd5;
    localparam logic [2:0] S_DEC  = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    logic [2:0]                   r_state, n_state;
    logic [PW-1:0]                r_period;
    logic [TB-1:0]                r_deadline;
    logic [TB-1:0]                r_now;
    logic [TB-1:0]                r_base;
    logic [TB-1:0]                r_next;
    logic [TB-1:0]                r_nd;
    logic [TB-1:0]                r_quo;      // dividend shifts out, quotient in
    logic [PW-1:0]                r_rem;
    logic [CNT_W-1:0]             r_cnt;
    logic                         r_behind;
    logic [fdp_pkg::SLEEP_W-1:0]  r_sleep;
    logic [fdp_pkg::DROP_W-1:0]   r_drop;

    logic                         r_ovalid;
    logic                         r_o_behind;
    logic [fdp_pkg::SLEEP_W-1:0]  r_o_sleep;
    logic [63:0]                  r_o_nd;
    logic [fdp_pkg::DROP_W-1:0]   r_o_drop;

    // Shared adder
    fdp_pkg::t_alu_op alu_op;
    logic [TB-1:0]    alu_a, alu_b, alu_sum;
    logic             alu_carry;

    fdp_alu #(.W(TB)) u_alu (
        .i_op    (alu_op),
        .i_a     (alu_a),
        .i_b     (alu_b),
        .o_sum   (alu_sum),
        .o_carry (alu_carry)
    );

    logic           in_acc;
    logic           out_load;
    logic [TB-1:0]  base_sel;
    logic [TB-1:0]  period_ext;
    logic [PW:0]    rem_sh;
    logic [63:0]    sum_wide;

    assign in_acc     = s_axis_tvalid && s_axis_tready;
    assign out_load   = (r_state == S_OUT) && (!r_ovalid || m_axis_tready);
    assign base_sel   = (r_deadline == '0) ? r_now : r_deadline;
    assign period_ext = TB'(r_period);
    assign rem_sh     = {r_rem, r_quo[TB-1]};
    assign sum_wide   = 64'(alu_sum);

    // Operand selection per sequencer step
    always_comb begin
        alu_op = fdp_pkg::ALU_ADD;
        alu_a  = r_now;
        alu_b  = period_ext;
        unique case (r_state)
            S_NEXT: begin
                alu_a = base_sel;
            end
            S_CMP: begin
                alu_op = fdp_pkg::ALU_SUB;
                alu_a  = r_next;
                alu_b  = r_now;
            end
            S_ELAP: begin
                alu_op = fdp_pkg::ALU_SUB;
                alu_b  = r_base;
            end
            S_DIV: begin
                alu_op = fdp_pkg::ALU_SUB;
                alu_a  = TB'(rem_sh);
            end
            S_DEC: begin
                alu_op = fdp_pkg::ALU_SUB;
                alu_a  = r_quo;
                alu_b  = TB'(1);
            end
            default: begin
                alu_op = fdp_pkg::ALU_ADD;
            end
        endcase
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (in_acc) n_state = S_NEXT;
            S_NEXT: n_state = S_CMP;
            S_CMP: begin
                if (!alu_carry || (alu_sum == '0)) n_state = S_ND;
                else                                n_state = S_OUT;
            end
            S_ND:   n_state = S_ELAP;
            S_ELAP: n_state = (r_period == '0) ? S_OUT : S_DIV;
            S_DIV:  if (r_cnt == CNT_W'(TB - 1)) n_state = S_DEC;
            S_DEC:  n_state = S_OUT;
            S_OUT:  if (out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_period   <= fdp_pkg::PERIOD_RESET;
            r_deadline <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) r_period <= i_cfg_data;
            if (out_load) begin
                r_deadline <= r_nd;
                r_ovalid   <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) r_now <= s_axis_tdata[TB-1:0];
            end
            S_NEXT: begin
                r_base <= base_sel;
                r_next <= alu_sum;
            end
            S_CMP: begin
                r_drop <= '0;
                if (!alu_carry || (alu_sum == '0)) begin
                    r_behind <= 1'b1;
                    r_sleep  <= '0;
                end else begin
                    r_behind <= 1'b0;
                    r_nd     <= r_next;
                    r_sleep  <= (sum_wide[63:31] != '0) ? fdp_pkg::SLEEP_MAX
                                                        : sum_wide[30:0];
                end
            end
            S_ND: begin
                r_nd <= alu_sum;
            end
            S_ELAP: begin
                r_quo <= alu_sum;
                r_rem <= '0;
                r_cnt <= '0;
            end
            S_DIV: begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (alu_carry) begin
                    r_rem <= alu_sum[PW-1:0];
                    r_quo <= {r_quo[TB-2:0], 1'b1};
                end else begin
                    r_rem <= rem_sh[PW-1:0];
                    r_quo <= {r_quo[TB-2:0], 1'b0};
                end
            end
            S_DEC: begin
                // periods above one: dropped = periods - 1, saturated
                if (r_quo[TB-1:1] != '0)
                    r_drop <= (sum_wide[63:32] != '0) ? fdp_pkg::DROP_MAX
                                                      : sum_wide[31:0];
                else
                    r_drop <= '0;
            end
            default: begin
                if (out_load) begin
                    r_o_behind <= r_behind;
                    r_o_sleep  <= r_sleep;
                    r_o_nd     <= 64'(r_nd);
                    r_o_drop   <= r_drop;
                end
            end
        endcase
    end

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {1'b0, r_o_drop, r_o_nd, r_o_sleep};
    assign m_axis_tuser  = r_o_behind;

`include "frame_deadline_pacer_top_assert.svh"

    `FDP_ASSERT_IMP(a_behind_no_sleep, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata[30:0] == '0, "behind result carries nonzero sleep")
    `FDP_ASSERT_IMP(a_ahead_no_drop, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata[126:95] == '0, "ahead result carries dropped frames")
    `FDP_ASSERT_IMP(a_zero_period_no_drop, i_clk, i_rst_n, m_axis_tvalid && (r_period == '0), m_axis_tdata[126:95] == '0, "dropped frames with zero period")
    `FDP_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, in_acc, !s_axis_tready, "input ready right after an accepted item")
    `FDP_ASSERT_NXT(a_deadline_follows_result, i_clk, i_rst_n, out_load, m_axis_tvalid && (64'(r_deadline) == m_axis_tdata[94:31]), "stored deadline differs from posted result")

endmodule

`default_nettype wire

@@ rtl/fdp_alu.sv @@
`default_nettype none

// Shared add/subtract unit; carry out is "no borrow" on subtract
module fdp_alu #(
    parameter int W = 64
) (
    input  wire logic          i_op,
    input  wire logic [W-1:0]  i_a,
    input  wire logic [W-1:0]  i_b,
    output logic      [W-1:0]  o_sum,
    output logic               o_carry
);

    logic [W-1:0] b_eff;
    logic [W:0]   full;

    always_comb begin
        b_eff = (i_op == fdp_pkg::ALU_SUB) ? ~i_b : i_b;
        full  = {1'b0, i_a} + {1'b0, b_eff} + (W+1)'(i_op == fdp_pkg::ALU_SUB);
    end

    assign o_sum   = full[W-1:0];
    assign o_carry = full[W];

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 1ps

// Frame pacing scoreboard: predicts each result from the frame times seen at the input
class pacer_scoreboard;
    typedef struct packed {
        logic        behind;
        logic [30:0] sleep_us;
        logic [63:0] next_deadline;
        logic [31:0] dropped_frames;
    } t_pace;

    logic [fdp_pkg::PERIOD_W-1:0] period = fdp_pkg::PERIOD_RESET;
    logic [63:0]                  deadline = '0;
    t_pace                        paces_due[$];
    int unsigned                  errors = 0;
    int unsigned                  frames = 0;
    int unsigned                  checked = 0;
    int unsigned                  behind_seen = 0;
    int unsigned                  dropped_seen = 0;
    int unsigned                  capped_seen = 0;

    function void set_period(logic [fdp_pkg::PERIOD_W-1:0] value);
        period = value;
    endfunction

    // One frame in, one pacing decision out; the chosen deadline becomes the new state
    function void note_frame(logic [63:0] now);
        logic [63:0] base;
        logic [63:0] cand;
        logic [63:0] elapsed;
        logic [63:0] periods;
        logic [63:0] gap;
        t_pace       p;
        base = (deadline == 0) ? now : deadline;   // zero deadline: not seeded yet
        cand = base + 64'(period);
        p    = '0;
        if (now >= cand) begin
            p.behind        = 1'b1;
            p.next_deadline = now + 64'(period);
            if (period != 0) begin
                elapsed = now - base;
                periods = elapsed / 64'(period);
                if (periods > 64'd1)
                    p.dropped_frames = (periods - 64'd1 > 64'(fdp_pkg::DROP_MAX)) ?
                                       fdp_pkg::DROP_MAX : 32'(periods - 64'd1);
            end
        end else begin
            gap             = cand - now;
            p.sleep_us      = (gap > 64'(fdp_pkg::SLEEP_MAX)) ? fdp_pkg::SLEEP_MAX : 31'(gap);
            p.next_deadline = cand;
        end
        deadline = p.next_deadline;
        paces_due.push_back(p);
        frames++;
        if (p.behind)
            behind_seen++;
        if (p.dropped_frames != 0)
            dropped_seen++;
        if (p.sleep_us == fdp_pkg::SLEEP_MAX)
            capped_seen++;
    endfunction

    function void compare(string field, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            errors++;
        end
    endfunction

    // tdata: [30:0] sleep_us, [94:31] next_deadline, [126:95] dropped_frames; tuser: behind
    function void check_pace(logic [127:0] data, logic [0:0] user);
        t_pace want;
        if (paces_due.size() == 0) begin
            $error("result with no frame outstanding: tdata=%h tuser=%b", data, user);
            errors++;
            return;
        end
        want = paces_due.pop_front();
        checked++;
        compare("behind", 64'(want.behind), 64'(user[0]));
        compare("sleep_us", 64'(want.sleep_us), 64'(data[30:0]));
        compare("next_deadline", want.next_deadline, data[94:31]);
        compare("dropped_frames", 64'(want.dropped_frames), 64'(data[126:95]));
    endfunction

    function void close();
        if (paces_due.size() != 0) begin
            $error("%0d results never arrived", paces_due.size());
            errors++;
        end
    endfunction
endclass

module tb;
    // Longest quiet stretch: long hold plus a full divide, a long random stall, many times over
    localparam int          STALL_LIMIT = 5000;
    localparam int          LONG_HOLD   = 400;
    localparam int          DRAIN_TAIL  = 80;
    localparam logic [63:0] TIME_TOP    = '1;
    localparam logic [23:0] PERIOD_TOP  = '1;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic [23:0]  i_cfg_data = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [63:0]  s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [127:0] m_axis_tdata;
    logic [0:0]   m_axis_tuser;

    pacer_scoreboard sb = new();

    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;
    logic        pressure_on = 1'b0;
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;
    int unsigned quiet_cycles = 0;

    frame_deadline_pacer_top #(
        .TIME_BITS(64)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Result side: random stalls, plus one long hold-off while pressure is requested
    always @(negedge i_clk) begin
        if (pressure_on && !hold_done) begin
            hold_left = LONG_HOLD;
            hold_done = 1'b1;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Monitor: sample handshakes at the rising edge, feed the scoreboard, run the watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                sb.set_period(i_cfg_data);
            if (s_axis_tvalid && s_axis_tready)
                sb.note_frame(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_pace(m_axis_tdata, m_axis_tuser);
            if ((i_cfg_valid && o_cfg_ready) || (s_axis_tvalid && s_axis_tready) ||
                (m_axis_tvalid && m_axis_tready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
                $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
                $display("status: fail");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Offer one frame time, with random idle cycles ahead of it
    task automatic offer_frame(input logic [63:0] now);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= now;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    // Period changes only once every outstanding result is back
    task automatic write_period(input logic [23:0] value);
        s_axis_tvalid <= 1'b0;
        while (sb.paces_due.size() != 0)
            @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly plausible frame times around the next candidate deadline, some noise
    function automatic logic [63:0] next_frame_time();
        logic [63:0] span;
        logic [63:0] target;
        int unsigned roll;
        span   = (sb.period == 0) ? 64'd1000 : 64'(sb.period);
        target = (sb.deadline == 0) ? {$urandom, $urandom} : sb.deadline + 64'(sb.period);
        roll   = $urandom_range(99);
        if (roll < 30)
            return target - 64'($urandom_range(32'(span), 1));
        if (roll < 35)
            return target;
        if (roll < 40)
            return target - 64'd1;
        if (roll < 60)
            return target + 64'($urandom_range(32'(span - 64'd1), 0));
        if (roll < 80)
            return target + 64'($urandom_range(40, 1)) * span +
                   64'($urandom_range(32'(span - 64'd1), 0));
        if (roll < 86)
            return target - {$urandom_range(3, 0), $urandom};   // clock stepped back
        if (roll < 94)
            return {$urandom, $urandom};
        case ($urandom_range(3))
            0: return 64'd0;
            1: return TIME_TOP;
            2: return 64'd0 - 64'(sb.period);                  // re-base lands on zero
            default: return target + span * 64'h1_0000_0000;   // dropped count saturates
        endcase
    endfunction

    task automatic run_frames(input int count);
        repeat (count)
            offer_frame(next_frame_time());
    endtask

    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        tx_idle_pct = 23;
        rx_idle_pct <= 88;

        // Directed, reset period
        offer_frame(64'd0);                                        // seeds from its own time
        offer_frame(sb.deadline + 64'(sb.period));                 // exactly on the deadline
        offer_frame(sb.deadline + 64'(sb.period) - 64'd1);         // one tick early
        offer_frame(sb.deadline + 64'(sb.period) * 64'd6 + 64'd3); // several periods late
        offer_frame(64'd5);                                        // clock stepped back
        offer_frame(TIME_TOP - 64'd19999);                         // deadline near the top
        offer_frame(TIME_TOP - 64'd4999);                          // candidate wraps, now below base
        offer_frame(64'd0 - 64'(sb.period));                       // deadline wraps to zero
        offer_frame(TIME_TOP);                                     // unseeded at the top
        offer_frame(64'h0000_0001_0000_0000);
        offer_frame(64'd7);                                        // far ahead, sleep capped
        offer_frame(64'hAAAA_AAAA_AAAA_AAAA);
        offer_frame(64'h5555_5555_5555_5555);

        // Directed, zero period: no dropped counting
        write_period(24'd0);
        offer_frame(64'd1000);
        offer_frame(TIME_TOP);
        offer_frame(TIME_TOP);
        offer_frame(64'd0);

        // Directed, largest period
        write_period(PERIOD_TOP);
        offer_frame(64'd0);
        offer_frame(sb.deadline + 64'(sb.period) * 64'd4 + 64'd9);
        offer_frame(64'd1);

        // Directed, unit period
        write_period(24'd1);
        offer_frame(sb.deadline + 64'd1);
        offer_frame(sb.deadline + 64'd101);
        offer_frame(sb.deadline + 64'h2_0000_0000);

        // Random, sender mostly busy, receiver mostly stalled
        write_period(fdp_pkg::PERIOD_RESET);
        run_frames(300);

        // Random, sender mostly idle, receiver mostly ready
        tx_idle_pct = 88;
        rx_idle_pct <= 23;
        write_period(24'($urandom_range(100000, 2)));
        run_frames(150);
        write_period(24'($urandom));
        run_frames(150);

        // No idling; a burst against a long receiver hold fills the block first
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        write_period(24'd1000);
        pressure_on <= 1'b1;
        run_frames(40);
        pressure_on <= 1'b0;
        write_period(24'd0);
        run_frames(60);
        write_period(PERIOD_TOP);
        run_frames(60);
        write_period(24'($urandom_range(5000, 1)));
        run_frames(90);

        // Drain, then give a stray result time to show up
        s_axis_tvalid <= 1'b0;
        while (sb.paces_due.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_TAIL) @(negedge i_clk);
        sb.close();

        $display("run covered %0d frames over several periods incl. zero and max, %0d checked",
                 sb.frames, sb.checked);
        $display("  %0d behind, %0d with dropped frames, %0d with capped sleep, %0d errors",
                 sb.behind_seen, sb.dropped_seen, sb.capped_seen, sb.errors);
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
